/* rtl/mcit_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mcit_pkg;

  localparam int CHANNELS  = 16;
  localparam int TICK_MS   = 20;

  localparam int CH_W      = 4;
  localparam int MASK_W    = 16;
  localparam int MS_W      = 16;
  localparam int LIMIT_W   = 12;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};

  // ceil(ms / TICK_MS) as (ms + TICK_MS - 1) * DIV_M >> DIV_SH, exact for 17-bit numerators
  localparam int DIV_IN_W  = MS_W + 1;
  localparam int DIV_SH    = DIV_IN_W + $clog2(TICK_MS);
  localparam longint DIV_M = ((longint'(1) << DIV_SH) + TICK_MS - 1) / TICK_MS;
  localparam int DIV_M_W   = DIV_IN_W + 1;
  localparam int PROD_W    = DIV_IN_W + DIV_M_W;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_STOP    = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_TICK    = 2'd3
  } mcit_mode_t;

  typedef struct packed {
    logic               en;
    mcit_mode_t         mode;
    logic [CH_W-1:0]    ch;
    logic               rep;
    logic [LIMIT_W-1:0] limit;
  } mcit_cmd_t;

  typedef struct packed {
    logic active;
    logic fire;
    logic clear;
  } mcit_cell_stat_t;

endpackage

`default_nettype wire

/* rtl/mcit_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module mcit_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [mcit_pkg::CH_W-1:0] idx,
  input  mcit_pkg::mcit_cmd_t       cmd,
  input  logic                      step,
  input  logic                      tok_in,
  output logic                      tok_out,
  output mcit_pkg::mcit_cell_stat_t stat
);
  import mcit_pkg::*;

  logic               active;
  logic               rep;
  logic               tok;
  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] count;
  logic [LIMIT_W-1:0] count_inc;
  logic               hit;
  logic               fire;
  logic               visit;

  assign hit       = cmd.en && (cmd.ch == idx);
  assign count_inc = count + LIMIT_W'(1);
  assign fire      = tok && active && (count_inc >= limit);
  assign visit     = step && tok && active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      tok    <= 1'b0;
    end else begin
      if (step) begin
        tok <= tok_in;
      end
      if (hit) begin
        case (cmd.mode)
          MODE_START: active <= 1'b1;
          MODE_STOP:  active <= 1'b0;
          default:    active <= active;
        endcase
      end else if (visit && fire && !rep) begin
        active <= 1'b0;
      end
    end
  end

  // per-channel settings, valid once a start has written them
  always_ff @(posedge clk) begin
    if (hit) begin
      case (cmd.mode)
        MODE_START: begin
          rep   <= cmd.rep;
          limit <= cmd.limit;
          count <= '0;
        end
        MODE_RESTART: count <= '0;
        default:      count <= count;
      endcase
    end else if (visit) begin
      count <= (fire && rep) ? '0 : count_inc;
    end
  end

  assign tok_out      = tok;
  assign stat.active  = active;
  assign stat.fire    = fire;
  assign stat.clear   = fire && !rep;

endmodule

`default_nettype wire

/* rtl/multi_channel_interval_timer.sv */
// command transaction: held, applied once the output is free, status in output register
// tick: the last result goes through start, one cell visit per cycle while the output
// is not stalled, the final result and the output register
// throughput set by the token walking the cell chain, one channel per unstalled cycle
// one held input transaction lets the next item in while a tick is being walked
// reset (rst, synchronous): all channels inactive, no transaction pending, output empty
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_interval_timer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  mode,
  input  logic [mcit_pkg::CH_W-1:0]   channel,
  input  logic                        repeat_mode,
  input  logic [mcit_pkg::MS_W-1:0]   interval_ms,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        fired,
  output logic [mcit_pkg::CH_W-1:0]   fired_channel,
  output logic [mcit_pkg::MASK_W-1:0] active_mask,
  output logic                        running,
  output logic                        last
);
  import mcit_pkg::*;

  localparam logic [MASK_W-1:0] CHAN_MASK = {MASK_W{1'b1}} >> (MASK_W - CHANNELS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state, state_next;

  // held input transaction, interval already turned into ticks
  logic               item_valid;
  mcit_mode_t         item_mode;
  logic [CH_W-1:0]    item_ch;
  logic               item_rep;
  logic [LIMIT_W-1:0] item_limit;

  logic               accept_in;
  logic               item_clr;

  // interval to tick limit: reciprocal multiply, then saturate
  logic [DIV_IN_W-1:0] div_in;
  logic [PROD_W-1:0]   div_prod;
  logic [DIV_IN_W-1:0] div_quot;
  logic [LIMIT_W-1:0]  limit_sat;

  // cell chain
  mcit_cmd_t         cmd;
  logic              step;
  logic              scan_start;
  logic              scan_step;
  logic [CHANNELS-1:0] tok_vec;
  logic [CHANNELS-1:0] fire_vec;
  mcit_cell_stat_t   stat [CHANNELS];

  logic [MASK_W-1:0] cur_mask;
  logic [MASK_W-1:0] cmd_mask;
  logic [MASK_W-1:0] chan_bit;
  logic [MASK_W-1:0] idx_bit;
  logic              any_fire;
  logic              any_clear;
  logic              tok_last;

  // scan bookkeeping: a fire is held back until the next fire or the scan end so the last one can be marked
  logic [CH_W-1:0]   scan_idx, scan_idx_next;
  logic              held_valid, held_valid_next;
  logic [CH_W-1:0]   held_ch, held_ch_next;
  logic [MASK_W-1:0] held_mask, held_mask_next;

  // output register
  logic              out_free;
  logic              emit;
  logic              e_fired;
  logic [CH_W-1:0]   e_ch;
  logic [MASK_W-1:0] e_mask;
  logic              e_last;

  assign in_stall  = item_valid;
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign div_in    = DIV_IN_W'(interval_ms) + DIV_IN_W'(TICK_MS - 1);
  assign div_prod  = PROD_W'(div_in) * PROD_W'(DIV_M);
  assign div_quot  = DIV_IN_W'(div_prod >> DIV_SH);
  assign limit_sat = (div_quot > DIV_IN_W'(LIMIT_MAX)) ? LIMIT_MAX : div_quot[LIMIT_W-1:0];

  assign step = scan_start || scan_step;

  always_comb begin
    cmd.mode  = item_mode;
    cmd.ch    = item_ch;
    cmd.rep   = item_rep;
    cmd.limit = item_limit;
    cmd.en    = 1'b0;
    if (state == ST_IDLE && item_valid && out_free && item_mode != MODE_TICK) begin
      cmd.en = 1'b1;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CHANNELS; gi++) begin : g_cell
      logic tok_prev;
      if (gi == 0) begin : g_head
        assign tok_prev = scan_start;
      end else begin : g_link
        assign tok_prev = tok_vec[gi-1];
      end
      mcit_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .idx     (CH_W'(gi)),
        .cmd     (cmd),
        .step    (step),
        .tok_in  (tok_prev),
        .tok_out (tok_vec[gi]),
        .stat    (stat[gi])
      );
    end
  endgenerate

  assign tok_last = tok_vec[CHANNELS-1];

  // gather mask and the visited cell's verdict
  always_comb begin
    cur_mask  = '0;
    fire_vec  = '0;
    any_clear = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      cur_mask[i] = stat[i].active;
      fire_vec[i] = stat[i].fire;
      any_clear   = any_clear | stat[i].clear;
    end
  end

  assign any_fire = |fire_vec;
  assign chan_bit = (MASK_W'(1) << item_ch) & CHAN_MASK;
  assign idx_bit  = MASK_W'(1) << scan_idx;

  always_comb begin
    case (item_mode)
      MODE_START: cmd_mask = cur_mask | chan_bit;
      MODE_STOP:  cmd_mask = cur_mask & ~chan_bit;
      default:    cmd_mask = cur_mask;
    endcase
  end

  always_comb begin
    state_next      = state;
    item_clr        = 1'b0;
    scan_start      = 1'b0;
    scan_step       = 1'b0;
    scan_idx_next   = scan_idx;
    held_valid_next = held_valid;
    held_ch_next    = held_ch;
    held_mask_next  = held_mask;
    emit            = 1'b0;
    e_fired         = 1'b0;
    e_ch            = '0;
    e_mask          = cur_mask;
    e_last          = 1'b1;
    case (state)
      ST_IDLE: begin
        if (item_valid && out_free) begin
          item_clr = 1'b1;
          if (item_mode == MODE_TICK) begin
            // token enters cell 0
            scan_start      = 1'b1;
            scan_idx_next   = '0;
            held_valid_next = 1'b0;
            state_next      = ST_SCAN;
          end else begin
            // command applied to the cells this cycle, status carries the new mask
            emit   = 1'b1;
            e_mask = cmd_mask;
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          scan_step     = 1'b1;
          scan_idx_next = scan_idx + CH_W'(1);
          if (any_fire) begin
            if (held_valid) begin
              emit    = 1'b1;
              e_fired = 1'b1;
              e_ch    = held_ch;
              e_mask  = held_mask;
              e_last  = 1'b0;
            end
            held_valid_next = 1'b1;
            held_ch_next    = scan_idx;
            held_mask_next  = cur_mask & ~(any_clear ? idx_bit : '0);
          end
          if (tok_last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          // last fire of the tick, or a plain status when none fired
          emit = 1'b1;
          if (held_valid) begin
            e_fired = 1'b1;
            e_ch    = held_ch;
            e_mask  = held_mask;
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
      held_valid <= 1'b0;
      scan_idx   <= '0;
    end else begin
      state      <= state_next;
      held_valid <= held_valid_next;
      scan_idx   <= scan_idx_next;
      if (accept_in) begin
        item_valid <= 1'b1;
      end else if (item_clr) begin
        item_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    // payload
    if (accept_in) begin
      item_mode  <= mcit_mode_t'(mode);
      item_ch    <= channel;
      item_rep   <= repeat_mode;
      item_limit <= limit_sat;
    end
    held_ch   <= held_ch_next;
    held_mask <= held_mask_next;
    if (emit) begin
      fired         <= e_fired;
      fired_channel <= e_ch;
      active_mask   <= e_mask;
      running       <= |e_mask;
      last          <= e_last;
    end
  end

`ifndef SYNTHESIS
  // exactly one cell holds the token while walking the chain
  a_tok_onehot: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> $onehot(tok_vec))
    else $error("token not one-hot during scan");

  // token position and scan index agree
  a_tok_idx: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> tok_vec[scan_idx])
    else $error("token and scan index disagree");

  // no token in the chain outside a scan
  a_tok_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_SCAN |-> tok_vec == '0)
    else $error("stray token outside scan");

  // a visit fires at most one channel
  a_one_fire: assert property (@(posedge clk) disable iff (rst)
    $onehot0(fire_vec))
    else $error("more than one channel fired in a cycle");

  // running flag follows the reported mask
  a_running: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> running == (active_mask != '0))
    else $error("running flag does not match mask");
`endif

endmodule

`default_nettype wire
